// ===== design/bracketed_command_line_parser_macros.svh =====
// Assertion macros for the bracketed command line parser.
// Each macro places one labelled concurrent assertion on the rising clock edge,
// disabled while the active-low reset is asserted.
`ifndef BRACKETED_COMMAND_LINE_PARSER_MACROS_SVH
`define BRACKETED_COMMAND_LINE_PARSER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define BCLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define BCLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BCLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BCLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/bclp_pkg.sv =====
`default_nettype none

package bclp_pkg;

    // Widths of the stream payloads.
    localparam int IN_TDATA_W  = 8;
    localparam int VALUE_W     = 32;
    localparam int ACTION_W    = 3;
    localparam int OUT_FIELD_W = ACTION_W + 2 * VALUE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Characters of interest.
    localparam logic [7:0] CH_IGNORE = 8'hFF;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    // Magnitude limits for a 32-bit signed value.
    localparam logic [VALUE_W-1:0] LIMIT_POS = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] LIMIT_NEG = 32'h8000_0000;

    // Action codes carried on the result stream.
    typedef enum logic [ACTION_W-1:0] {
        ACT_START     = 3'd0,
        ACT_STOP      = 3'd1,
        ACT_QUIT      = 3'd2,
        ACT_BAD_CMD   = 3'd3,
        ACT_BAD_START = 3'd4,
        ACT_BAD_STOP  = 3'd5
    } t_action;

    // Line parser mode, one-hot.
    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_WORD    = 5'b00010,
        MODE_VALUE   = 5'b00100,
        MODE_QUIT    = 5'b01000,
        MODE_INVALID = 5'b10000
    } t_mode;

    // Number extraction phases.
    localparam logic [2:0] PH_FIRST_BLANK   = 3'd0;
    localparam logic [2:0] PH_FIRST_SIGN    = 3'd1;
    localparam logic [2:0] PH_FIRST_DIGITS  = 3'd2;
    localparam logic [2:0] PH_SECOND_BLANK  = 3'd3;
    localparam logic [2:0] PH_SECOND_SIGN   = 3'd4;
    localparam logic [2:0] PH_SECOND_DIGITS = 3'd5;
    localparam logic [2:0] PH_DONE          = 3'd6;
    localparam logic [2:0] PH_FAIL          = 3'd7;

    // Match-flag bit positions.
    localparam int FLAG_START = 0;
    localparam int FLAG_STOP  = 1;
    localparam int FLAG_QUIT  = 2;

    // Number being extracted.
    typedef struct packed {
        logic [2:0]         phase;
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_num;

    // Whether byte c matches the command word at position pos.
    function automatic logic start_match(input logic [2:0] pos, input logic [7:0] c);
        logic m;
        case (pos)
            3'd0:    m = (c == "s");
            3'd1:    m = (c == "t");
            3'd2:    m = (c == "a");
            3'd3:    m = (c == "r");
            3'd4:    m = (c == "t");
            default: m = 1'b0;
        endcase
        return m;
    endfunction

    function automatic logic stop_match(input logic [2:0] pos, input logic [7:0] c);
        logic m;
        case (pos)
            3'd0:    m = (c == "s");
            3'd1:    m = (c == "t");
            3'd2:    m = (c == "o");
            3'd3:    m = (c == "p");
            default: m = 1'b0;
        endcase
        return m;
    endfunction

    function automatic logic quit_match(input logic [2:0] pos, input logic [7:0] c);
        logic m;
        case (pos)
            3'd0:    m = (c == "q");
            3'd1:    m = (c == "u");
            3'd2:    m = (c == "i");
            3'd3:    m = (c == "t");
            default: m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/bracketed_command_line_parser.sv =====
// Bracketed command line parser.
// The slave stream (s_axis_*) carries one received byte per transaction. Lines of
// the form "<start> d p", "<stop> d" and "<quit>" ended by CR or LF produce one
// transaction on the master stream (m_axis_*) holding an action code and the
// parsed indices; error lines produce a bad-command or bad-index action, and a
// line end with no pending command produces nothing. Byte 0xFF is dropped.
// A byte accepted is held in the input register and parsed there; a result it
// causes is registered in the result register and presented on m_axis_tvalid.
// Throughput: one byte per cycle while the receiver takes results; the input
// register and the result register are refilled whenever the result register is
// free, and the multiply-by-ten and range compare on the running magnitude are combinational.
// When the receiver stalls with a result pending, the parser holds that result,
// still takes one more byte into its input register if that register is empty,
// and then deasserts s_axis_tready until the result is taken.
// A synchronous active-low reset empties both registers and returns the parser
// to idle with all number state cleared; it keeps running after a quit line.
`default_nettype none

`include "bracketed_command_line_parser_macros.svh"

module bracketed_command_line_parser (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] rx_byte
    input  wire [bclp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [2:0] action, [34:3] director_index, [66:35] play_index, [71:67] zero
    output logic [bclp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int VW = bclp_pkg::VALUE_W;

    // Input and result registers.
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    bclp_pkg::t_action     r_out_action;
    logic [VW-1:0]         r_out_director;
    logic [VW-1:0]         r_out_play;

    // Parser state.
    bclp_pkg::t_mode       r_mode, n_mode;
    logic [2:0]            r_wlen, n_wlen;
    logic [2:0]            r_flags, n_flags;
    logic                  r_kind_stop, n_kind_stop;
    bclp_pkg::t_num        r_num, n_num;
    logic [VW-1:0]         r_first, n_first;

    // Result of the byte in the input register.
    logic                  w_emit;
    bclp_pkg::t_action     w_action;
    logic [VW-1:0]         w_director;
    logic [VW-1:0]         w_play;

    logic                  w_adv;
    logic                  w_take;
    logic [7:0]            w_c;
    logic                  w_is_eol;
    logic                  w_is_blank;
    logic                  w_is_digit;
    logic                  w_is_sign;
    logic [3:0]            w_digit;
    logic [VW-1:0]         w_signed;
    logic [VW+3:0]         w_acc;
    logic [VW+3:0]         w_lim;

    // Start a number: skip blanks, take a sign or a first digit, else fail.
    function automatic bclp_pkg::t_num num_begin(
        input bclp_pkg::t_num cur,
        input logic           second,
        input logic           blank,
        input logic           sign,
        input logic           minus,
        input logic           digit,
        input logic [3:0]     dval
    );
        bclp_pkg::t_num r;
        r = cur;
        r.phase = second ? bclp_pkg::PH_SECOND_BLANK : bclp_pkg::PH_FIRST_BLANK;
        if (blank) begin
            r.phase = r.phase;
        end else if (sign) begin
            r.neg   = minus;
            r.mag   = '0;
            r.phase = second ? bclp_pkg::PH_SECOND_SIGN : bclp_pkg::PH_FIRST_SIGN;
        end else if (digit) begin
            r.neg   = 1'b0;
            r.mag   = {{(VW-4){1'b0}}, dval};
            r.phase = second ? bclp_pkg::PH_SECOND_DIGITS : bclp_pkg::PH_FIRST_DIGITS;
        end else begin
            r.phase = bclp_pkg::PH_FAIL;
        end
        return r;
    endfunction

    // Handshake: the parser advances whenever the result register is free or its result is being taken.
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_take        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    // Byte classification.
    assign w_c        = r_in_byte;
    assign w_is_eol   = (w_c == bclp_pkg::CH_CR) || (w_c == bclp_pkg::CH_LF);
    assign w_is_blank = w_c inside {8'h20, 8'h09, 8'h0B, 8'h0C};
    assign w_is_digit = w_c inside {[8'h30:8'h39]};
    assign w_is_sign  = (w_c == bclp_pkg::CH_PLUS) || (w_c == bclp_pkg::CH_MINUS);
    assign w_digit    = w_c[3:0];

    // Running value arithmetic: magnitude times ten plus digit, and the sign.
    assign w_acc    = {1'b0, r_num.mag, 3'b000} + {3'b000, r_num.mag, 1'b0}
                    + {{VW{1'b0}}, w_digit};
    assign w_lim    = {4'b0000, r_num.neg ? bclp_pkg::LIMIT_NEG : bclp_pkg::LIMIT_POS};
    assign w_signed = r_num.neg ? (VW'(0) - r_num.mag) : r_num.mag;

    // Next-state and result logic for the byte in the input register.
    always_comb begin
        n_mode      = r_mode;
        n_wlen      = r_wlen;
        n_flags     = r_flags;
        n_kind_stop = r_kind_stop;
        n_num       = r_num;
        n_first     = r_first;
        w_emit      = 1'b0;
        w_action    = bclp_pkg::ACT_BAD_CMD;
        w_director  = '0;
        w_play      = '0;

        if (w_c == bclp_pkg::CH_IGNORE) begin
            n_mode = r_mode;
        end else if (w_c == bclp_pkg::CH_LT && r_mode == bclp_pkg::MODE_IDLE) begin
            n_mode  = bclp_pkg::MODE_WORD;
            n_wlen  = '0;
            n_flags = 3'b111;
        end else if (w_c == bclp_pkg::CH_GT && r_mode == bclp_pkg::MODE_WORD) begin
            // Close the command word.
            if (r_flags[bclp_pkg::FLAG_START] && r_wlen == 3'd5) begin
                n_kind_stop = 1'b0;
                n_mode      = bclp_pkg::MODE_VALUE;
            end else if (r_flags[bclp_pkg::FLAG_STOP] && r_wlen == 3'd4) begin
                n_kind_stop = 1'b1;
                n_mode      = bclp_pkg::MODE_VALUE;
            end else if (r_flags[bclp_pkg::FLAG_QUIT] && r_wlen == 3'd4) begin
                n_mode = bclp_pkg::MODE_QUIT;
            end else begin
                n_mode = bclp_pkg::MODE_INVALID;
            end
            n_num.phase = bclp_pkg::PH_FIRST_BLANK;
            n_num.neg   = 1'b0;
            n_num.mag   = '0;
        end else if (w_is_eol) begin
            // Line end: report the command, if any, and go idle.
            n_mode = bclp_pkg::MODE_IDLE;
            case (r_mode)
                bclp_pkg::MODE_QUIT: begin
                    w_emit   = 1'b1;
                    w_action = bclp_pkg::ACT_QUIT;
                end
                bclp_pkg::MODE_WORD, bclp_pkg::MODE_INVALID: begin
                    w_emit   = 1'b1;
                    w_action = bclp_pkg::ACT_BAD_CMD;
                end
                bclp_pkg::MODE_VALUE: begin
                    w_emit = 1'b1;
                    if (r_kind_stop) begin
                        if (r_num.phase == bclp_pkg::PH_FIRST_DIGITS) begin
                            w_action   = bclp_pkg::ACT_STOP;
                            w_director = w_signed;
                        end else if (r_num.phase == bclp_pkg::PH_DONE) begin
                            w_action   = bclp_pkg::ACT_STOP;
                            w_director = r_first;
                        end else begin
                            w_action = bclp_pkg::ACT_BAD_STOP;
                        end
                    end else begin
                        if (r_num.phase == bclp_pkg::PH_SECOND_DIGITS
                            || r_num.phase == bclp_pkg::PH_DONE) begin
                            w_action   = bclp_pkg::ACT_START;
                            w_director = r_first;
                            w_play     = w_signed;
                        end else begin
                            w_action = bclp_pkg::ACT_BAD_START;
                        end
                    end
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end else if (r_mode == bclp_pkg::MODE_WORD) begin
            // Track which command words are still a match.
            if (!bclp_pkg::start_match(r_wlen, w_c)) n_flags[bclp_pkg::FLAG_START] = 1'b0;
            if (!bclp_pkg::stop_match(r_wlen, w_c))  n_flags[bclp_pkg::FLAG_STOP]  = 1'b0;
            if (!bclp_pkg::quit_match(r_wlen, w_c))  n_flags[bclp_pkg::FLAG_QUIT]  = 1'b0;
            if (r_wlen != 3'd7) n_wlen = r_wlen + 3'd1;
        end else if (r_mode == bclp_pkg::MODE_VALUE) begin
            // Extract the decimal values.
            if (r_num.phase == bclp_pkg::PH_FIRST_BLANK
                || r_num.phase == bclp_pkg::PH_SECOND_BLANK) begin
                n_num = num_begin(r_num, r_num.phase == bclp_pkg::PH_SECOND_BLANK,
                                  w_is_blank, w_is_sign, w_c == bclp_pkg::CH_MINUS,
                                  w_is_digit, w_digit);
            end else if (r_num.phase == bclp_pkg::PH_FIRST_SIGN
                         || r_num.phase == bclp_pkg::PH_SECOND_SIGN) begin
                if (w_is_digit) begin
                    n_num.mag   = {{(VW-4){1'b0}}, w_digit};
                    n_num.phase = (r_num.phase == bclp_pkg::PH_SECOND_SIGN)
                                ? bclp_pkg::PH_SECOND_DIGITS : bclp_pkg::PH_FIRST_DIGITS;
                end else begin
                    n_num.phase = bclp_pkg::PH_FAIL;
                end
            end else if (r_num.phase == bclp_pkg::PH_FIRST_DIGITS
                         || r_num.phase == bclp_pkg::PH_SECOND_DIGITS) begin
                if (w_is_digit) begin
                    if (w_acc > w_lim) begin
                        n_num.phase = bclp_pkg::PH_FAIL;
                    end else begin
                        n_num.mag = w_acc[VW-1:0];
                    end
                end else if (r_num.phase == bclp_pkg::PH_FIRST_DIGITS) begin
                    // First number ends; for start this byte begins the second.
                    n_first = w_signed;
                    if (r_kind_stop) begin
                        n_num.phase = bclp_pkg::PH_DONE;
                    end else begin
                        n_num = num_begin(r_num, 1'b1, w_is_blank, w_is_sign,
                                          w_c == bclp_pkg::CH_MINUS, w_is_digit, w_digit);
                    end
                end else begin
                    n_num.phase = bclp_pkg::PH_DONE;
                end
            end
        end else begin
            n_mode = bclp_pkg::MODE_INVALID;
        end
    end

    // Control and parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= bclp_pkg::MODE_IDLE;
            r_wlen      <= '0;
            r_flags     <= '0;
            r_kind_stop <= 1'b0;
            r_num       <= '0;
            r_first     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid && w_emit;
            end
            if (w_take) begin
                r_mode      <= n_mode;
                r_wlen      <= n_wlen;
                r_flags     <= n_flags;
                r_kind_stop <= n_kind_stop;
                r_num       <= n_num;
                r_first     <= n_first;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_take) begin
            r_out_action   <= w_action;
            r_out_director <= w_director;
            r_out_play     <= w_play;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{bclp_pkg::OUT_PAD_W{1'b0}}, r_out_play, r_out_director,
                            r_out_action};

    // Checks on the parser's own logic.
    `BCLP_ASSERT_IMP(a_action_range, i_clk, i_rst_n, r_out_valid,
        r_out_action == bclp_pkg::ACT_START || r_out_action == bclp_pkg::ACT_STOP
        || r_out_action == bclp_pkg::ACT_QUIT || r_out_action == bclp_pkg::ACT_BAD_CMD
        || r_out_action == bclp_pkg::ACT_BAD_START || r_out_action == bclp_pkg::ACT_BAD_STOP,
        "result action code out of range")
    `BCLP_ASSERT_IMP(a_error_zero, i_clk, i_rst_n,
        r_out_valid && (r_out_action == bclp_pkg::ACT_QUIT
        || r_out_action == bclp_pkg::ACT_BAD_CMD || r_out_action == bclp_pkg::ACT_BAD_START
        || r_out_action == bclp_pkg::ACT_BAD_STOP),
        r_out_director == '0 && r_out_play == '0,
        "quit or error result carries non-zero indices")
    `BCLP_ASSERT_IMP(a_stop_no_play, i_clk, i_rst_n,
        r_out_valid && r_out_action == bclp_pkg::ACT_STOP, r_out_play == '0,
        "stop result carries a play index")
    `BCLP_ASSERT_NXT(a_eol_idle, i_clk, i_rst_n, w_take && w_is_eol,
        r_mode == bclp_pkg::MODE_IDLE, "line end did not return parser to idle")
    `BCLP_ASSERT_NXT(a_result_source, i_clk, i_rst_n, w_adv && !(w_take && w_emit),
        !r_out_valid, "result presented without an emitting byte")

endmodule

`default_nettype wire
